### rtl/ipv4fdg_pkg.sv
package ipv4fdg_pkg;

  // Result status codes as they appear on the status output.
  typedef enum logic [1:0] {
    STATUS_WHOLE   = 2'd0,
    STATUS_FRAG    = 2'd1,
    STATUS_TOO_BIG = 2'd2,
    STATUS_BAD_LEN = 2'd3
  } status_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_CHECK,
    ST_EMIT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic calc;
    logic check;
    logic emit;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
    logic last;
  } dp_stat_t;

  localparam logic [15:0] MtuReset       = 16'd1500;
  localparam int          MaxFrags       = 64;
  localparam int          BlockBytes     = 8;
  localparam int          WordBytes      = 4;
  localparam int          MinHeaderWords = 5;
  localparam int          BlockShift     = $clog2(BlockBytes);
  localparam int          WordShift      = $clog2(WordBytes);
  localparam int          LimitShift     = $clog2(MaxFrags * BlockBytes);

endpackage

### rtl/ipv4fdg_ctrl.sv
module ipv4fdg_ctrl
  import ipv4fdg_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands. A packet is loaded, evaluated in two steps, and
  // then one result is handed to the output register per free slot.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CALC;
        end
      end
      ST_CALC: begin
        cmd_o.calc = 1'b1;
        state_d    = ST_CHECK;
      end
      ST_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (stat_i.last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/ipv4fdg_dp.sv
module ipv4fdg_dp
  import ipv4fdg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dp_cmd_t     cmd_i,
  output dp_stat_t    stat_o,
  input  logic        mtu_we_i,
  input  logic [15:0] mtu_wdata_i,
  output logic [15:0] mtu_o,
  input  logic [15:0] total_length_i,
  input  logic [3:0]  header_words_i,
  input  logic        dont_fragment_i,
  input  logic [31:0] payload_base_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [12:0] fragment_offset_o,
  output logic [15:0] fragment_length_o,
  output logic        frag_more_o,
  output logic [31:0] payload_address_o,
  output logic        last_result_o
);

  logic [15:0] mtu_q;

  // Captured packet descriptor.
  logic [15:0] total_q;
  logic [3:0]  hw_q;
  logic        df_q;
  logic [31:0] base_q;

  // Evaluation results.
  logic [5:0]  hl_q;
  logic        bad_q;
  logic        fits_q;
  logic [12:0] nfb_q;
  logic [15:0] pay_len_q;
  status_e     kind_q;

  // Fragment walk.
  logic [15:0] left_q;
  logic [15:0] start_q;
  logic [12:0] off_q;

  // Output register.
  logic        out_valid_q;
  status_e     status_q;
  logic [12:0] offset_q;
  logic [15:0] length_q;
  logic        mf_q;
  logic [31:0] addr_q;
  logic        last_q;

  logic [5:0]  hl_calc;
  logic [15:0] mtu_room;
  logic [15:0] chunk;
  logic [21:0] frag_limit;
  logic        too_many;
  logic        last_frag;
  logic [15:0] piece;
  logic        single;

  // Header length in bytes and the room the MTU leaves after it.
  assign hl_calc  = 6'(hw_q) << WordShift;
  assign mtu_room = mtu_q - 16'(hl_calc);

  // Payload bytes per full fragment, and the most payload the fragment
  // count limit allows.
  assign chunk      = {nfb_q, {BlockShift{1'b0}}};
  assign frag_limit = 22'({nfb_q, {LimitShift{1'b0}}});
  assign too_many   = 22'(pay_len_q) > frag_limit;

  // The current fragment is the final one when the rest fits a full chunk.
  assign single    = (kind_q != STATUS_FRAG);
  assign last_frag = (left_q <= chunk);
  assign piece     = last_frag ? left_q : chunk;

  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign stat_o.last     = single || last_frag;

  // MTU register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mtu_q <= MtuReset;
    end else if (mtu_we_i) begin
      mtu_q <= mtu_wdata_i;
    end
  end

  // Descriptor capture on an input transfer.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      total_q <= total_length_i;
      hw_q    <= header_words_i;
      df_q    <= dont_fragment_i;
      base_q  <= payload_base_i;
    end
  end

  // First evaluation step: length checks and block count per fragment.
  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      hl_q      <= hl_calc;
      bad_q     <= (hw_q < 4'(MinHeaderWords)) || (total_q < 16'(hl_calc));
      fits_q    <= (total_q <= mtu_q);
      nfb_q     <= (mtu_q >= 16'(hl_calc)) ? mtu_room[15:BlockShift] : '0;
      pay_len_q <= total_q - 16'(hl_calc);
    end
  end

  // Second evaluation step: decide the kind of result and start the walk.
  always_ff @(posedge clk_i) begin
    if (cmd_i.check) begin
      priority if (bad_q) begin
        kind_q <= STATUS_BAD_LEN;
      end else if (fits_q) begin
        kind_q <= STATUS_WHOLE;
      end else if (df_q) begin
        kind_q <= STATUS_TOO_BIG;
      end else if (nfb_q == '0 || too_many) begin
        kind_q <= STATUS_BAD_LEN;
      end else begin
        kind_q <= STATUS_FRAG;
      end
      left_q  <= pay_len_q;
      start_q <= '0;
      off_q   <= '0;
    end else if (cmd_i.emit) begin
      left_q  <= left_q - chunk;
      start_q <= start_q + chunk;
      off_q   <= off_q + nfb_q;
    end
  end

  // Output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      status_q <= kind_q;
      unique case (kind_q)
        STATUS_WHOLE: begin
          offset_q <= '0;
          length_q <= total_q;
          mf_q     <= 1'b0;
          addr_q   <= base_q;
          last_q   <= 1'b1;
        end
        STATUS_FRAG: begin
          offset_q <= off_q;
          length_q <= 16'(hl_q) + piece;
          mf_q     <= !last_frag;
          addr_q   <= base_q + 32'(start_q);
          last_q   <= last_frag;
        end
        default: begin
          offset_q <= '0;
          length_q <= '0;
          mf_q     <= 1'b0;
          addr_q   <= '0;
          last_q   <= 1'b1;
        end
      endcase
    end
  end

  assign mtu_o             = mtu_q;
  assign out_valid_o       = out_valid_q;
  assign status_o          = status_q;
  assign fragment_offset_o = offset_q;
  assign fragment_length_o = length_q;
  assign frag_more_o       = mf_q;
  assign payload_address_o = addr_q;
  assign last_result_o     = last_q;

endmodule

### rtl/ipv4_fragment_descriptor_gen.sv
// Channel   Handshake                  Payload
// input     in_valid_i / in_ready_o    total_length_i, header_words_i, dont_fragment_i,
//                                      payload_base_i
// result    out_valid_o / out_ready_i  status_o, fragment_offset_o, fragment_length_o,
//                                      frag_more_o, payload_address_o, last_result_o
// config    mtu_we_i                   mtu_wdata_i
//
// After its transfer a packet passes the calc and check evaluation steps; then the emit
// step hands out its results, at most 64 of them. The rate is set by the emit step, which
// loads one descriptor per cycle into the output register whenever that register is free.
// Reset clears the controller and the output valid flag and sets the MTU to 1500.
// A stalled result holds the emit step; the next packet is taken while the final
// result of the previous one still waits in the output register.
module ipv4_fragment_descriptor_gen
  import ipv4fdg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        mtu_we_i,
  input  logic [15:0] mtu_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] total_length_i,
  input  logic [3:0]  header_words_i,
  input  logic        dont_fragment_i,
  input  logic [31:0] payload_base_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [12:0] fragment_offset_o,
  output logic [15:0] fragment_length_o,
  output logic        frag_more_o,
  output logic [31:0] payload_address_o,
  output logic        last_result_o
);

  dp_cmd_t     cmd;
  dp_stat_t    stat;
  logic [15:0] mtu;

  ipv4fdg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ipv4fdg_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .mtu_we_i          (mtu_we_i),
    .mtu_wdata_i       (mtu_wdata_i),
    .mtu_o             (mtu),
    .total_length_i    (total_length_i),
    .header_words_i    (header_words_i),
    .dont_fragment_i   (dont_fragment_i),
    .payload_base_i    (payload_base_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .status_o          (status_o),
    .fragment_offset_o (fragment_offset_o),
    .fragment_length_o (fragment_length_o),
    .frag_more_o       (frag_more_o),
    .payload_address_o (payload_address_o),
    .last_result_o     (last_result_o)
  );

  // The more-fragments flag is set exactly on results that are not final.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (frag_more_o == !last_result_o))
    else $error("frag_more disagrees with last_result");

  // Results other than fragments always sit at offset zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != STATUS_FRAG) |-> (fragment_offset_o == '0))
    else $error("non-fragment result with nonzero offset");

  // No fragment is ever longer than the MTU.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == STATUS_FRAG) |-> (fragment_length_o <= mtu))
    else $error("fragment exceeds MTU");

  // No result is emitted while a newly accepted packet is still being evaluated.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !cmd.emit ##1 !cmd.emit)
    else $error("emit during packet evaluation");

endmodule

### tb/frag_checker.sv
module frag_checker
  import ipv4fdg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        mtu_we_i,
  input  logic [15:0] mtu_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [15:0] total_length_i,
  input  logic [3:0]  header_words_i,
  input  logic        dont_fragment_i,
  input  logic [31:0] payload_base_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  status_i,
  input  logic [12:0] fragment_offset_i,
  input  logic [15:0] fragment_length_i,
  input  logic        frag_more_i,
  input  logic [31:0] payload_address_i,
  input  logic        last_result_i,
  output int          mismatch_count_o,
  output int          frags_due_o
);

  // One descriptor as it should leave the block.
  typedef struct packed {
    status_e     status;
    logic [12:0] offset;
    logic [15:0] length;
    logic        more;
    logic [31:0] address;
    logic        last;
  } frag_desc_t;

  frag_desc_t  pending_frags[$];
  logic [15:0] mtu_shadow;

  // Pushes a single-result outcome: whole packet or one of the error codes.
  task automatic push_single(input status_e status, input logic [15:0] length,
                             input logic [31:0] address);
    frag_desc_t d;
    d.status  = status;
    d.offset  = '0;
    d.length  = length;
    d.more    = 1'b0;
    d.address = address;
    d.last    = 1'b1;
    pending_frags.push_back(d);
  endtask

  // Works out every descriptor that one packet transfer must produce.
  task automatic plan_fragments(input logic [15:0] total, input logic [3:0] words,
                                input logic df, input logic [31:0] base);
    int unsigned hdr_len, pay_len, blocks, chunk, count, start, piece;
    frag_desc_t  d;
    hdr_len = words * WordBytes;
    if (words < MinHeaderWords || total < hdr_len) begin
      push_single(STATUS_BAD_LEN, '0, '0);
    end else if (total <= mtu_shadow) begin
      push_single(STATUS_WHOLE, total, base);
    end else if (df) begin
      push_single(STATUS_TOO_BIG, '0, '0);
    end else begin
      blocks  = (mtu_shadow >= hdr_len) ? (mtu_shadow - hdr_len) / BlockBytes : 0;
      chunk   = blocks * BlockBytes;
      pay_len = total - hdr_len;
      count   = (chunk == 0) ? 0 : (pay_len + chunk - 1) / chunk;
      if (blocks == 0 || count == 0 || count > MaxFrags) begin
        push_single(STATUS_BAD_LEN, '0, '0);
      end else begin
        // Full-size fragments first, the remainder rides in the last one.
        for (int unsigned i = 0; i < count; i++) begin
          start     = i * chunk;
          piece     = (pay_len - start < chunk) ? pay_len - start : chunk;
          d.status  = STATUS_FRAG;
          d.offset  = 13'(i * blocks);
          d.length  = 16'(hdr_len + piece);
          d.more    = (i + 1 != count);
          d.address = base + 32'(start);
          d.last    = (i + 1 == count);
          pending_frags.push_back(d);
        end
      end
    end
  endtask

  // Compares each result transfer against the oldest prediction, then
  // records new predictions and MTU writes seen at the same edge.
  always @(posedge clk_i) begin
    frag_desc_t want;
    if (!rst_ni) begin
      mtu_shadow       = MtuReset;
      mismatch_count_o = 0;
      pending_frags.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (pending_frags.size() == 0) begin
          $error("unexpected result: status %0d offset %0d length %0d",
                 status_i, fragment_offset_i, fragment_length_i);
          mismatch_count_o++;
        end else begin
          want = pending_frags.pop_front();
          if (status_i !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status_i);
            mismatch_count_o++;
          end
          if (fragment_offset_i !== want.offset) begin
            $error("fragment_offset: expected %0d, actual %0d", want.offset,
                   fragment_offset_i);
            mismatch_count_o++;
          end
          if (fragment_length_i !== want.length) begin
            $error("fragment_length: expected %0d, actual %0d", want.length,
                   fragment_length_i);
            mismatch_count_o++;
          end
          if (frag_more_i !== want.more) begin
            $error("frag_more: expected %0d, actual %0d", want.more,
                   frag_more_i);
            mismatch_count_o++;
          end
          if (payload_address_i !== want.address) begin
            $error("payload_address: expected %h, actual %h", want.address,
                   payload_address_i);
            mismatch_count_o++;
          end
          if (last_result_i !== want.last) begin
            $error("last_result: expected %0d, actual %0d", want.last, last_result_i);
            mismatch_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        plan_fragments(total_length_i, header_words_i, dont_fragment_i, payload_base_i);
      end
      if (mtu_we_i) begin
        mtu_shadow = mtu_wdata_i;
      end
    end
    frags_due_o = pending_frags.size();
  end

endmodule

### tb/testbench.sv
module testbench;
  import ipv4fdg_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        mtu_we_i;
  logic [15:0] mtu_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [15:0] total_length_i;
  logic [3:0]  header_words_i;
  logic        dont_fragment_i;
  logic [31:0] payload_base_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  status_o;
  logic [12:0] fragment_offset_o;
  logic [15:0] fragment_length_o;
  logic        frag_more_o;
  logic [31:0] payload_address_o;
  logic        last_result_o;

  int mismatch_count;
  int frags_due;
  int mtu_now;
  bit steady;

  ipv4_fragment_descriptor_gen uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .mtu_we_i          (mtu_we_i),
    .mtu_wdata_i       (mtu_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .total_length_i    (total_length_i),
    .header_words_i    (header_words_i),
    .dont_fragment_i   (dont_fragment_i),
    .payload_base_i    (payload_base_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .status_o          (status_o),
    .fragment_offset_o (fragment_offset_o),
    .fragment_length_o (fragment_length_o),
    .frag_more_o       (frag_more_o),
    .payload_address_o (payload_address_o),
    .last_result_o     (last_result_o)
  );

  frag_checker checker_i (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .mtu_we_i          (mtu_we_i),
    .mtu_wdata_i       (mtu_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_i        (in_ready_o),
    .total_length_i    (total_length_i),
    .header_words_i    (header_words_i),
    .dont_fragment_i   (dont_fragment_i),
    .payload_base_i    (payload_base_i),
    .out_valid_i       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .status_i          (status_o),
    .fragment_offset_i (fragment_offset_o),
    .fragment_length_i (fragment_length_o),
    .frag_more_i       (frag_more_o),
    .payload_address_i (payload_address_o),
    .last_result_i     (last_result_o),
    .mismatch_count_o  (mismatch_count),
    .frags_due_o       (frags_due)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Result side: bursts of ready separated by random stalls.
  initial begin : ready_pacer
    int unsigned run, hold;
    out_ready_i = 1'b0;
    @(posedge clk_i);
    forever begin
      out_ready_i <= 1'b1;
      run = $urandom_range(1, 12);
      repeat (run) @(posedge clk_i);
      hold = pick_gap();
      if (hold != 0) begin
        out_ready_i <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
    end
  end

  // Offers one packet descriptor and returns at the edge of its transfer.
  task automatic send_packet(input logic [15:0] total, input logic [3:0] words,
                             input logic df, input logic [31:0] base);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    total_length_i  <= total;
    header_words_i  <= words;
    dont_fragment_i <= df;
    payload_base_i  <= base;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Holds off the sender until every predicted descriptor has come out.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (frags_due != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // MTU changes happen only with the block idle.
  task automatic retune_mtu(input int value);
    drain_results();
    mtu_we_i    <= 1'b1;
    mtu_wdata_i <= 16'(value);
    mtu_now      = value;
    @(posedge clk_i);
    mtu_we_i <= 1'b0;
  endtask

  // Random packets shaped around the current MTU so that whole packets,
  // fragment trains and boundary lengths all show up.
  task automatic random_packets(input int n);
    logic [3:0] words;
    int         hdr, total, blocks, lo;
    int unsigned r;
    for (int k = 0; k < n; k++) begin
      words = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(0, 4))
                                           : 4'($urandom_range(5, 15));
      hdr   = int'(words) * 4;
      r     = $urandom_range(0, 9);
      lo    = (mtu_now < 65535) ? mtu_now + 1 : 65535;
      case (r)
        0, 1, 2: total = $urandom_range(hdr, mtu_now);
        3, 4, 5, 6: total = $urandom_range(lo, 65535);
        7: total = $urandom_range(0, 65535);
        8: total = mtu_now - 1 + $urandom_range(0, 2);
        default: begin
          blocks = (mtu_now > hdr) ? (mtu_now - hdr) / 8 : 0;
          if ($urandom_range(0, 1) == 1) total = hdr + $urandom_range(1, 4) * blocks * 8;
          else total = hdr - 1 + $urandom_range(0, 1);
        end
      endcase
      if (total > 65535) total = 65535;
      if (total < 0) total = 0;
      send_packet(16'(total), words, ($urandom_range(0, 3) == 0), $urandom());
    end
  endtask

  // Stimulus: reset, directed corners, random phases at several MTUs.
  initial begin
    mtu_we_i        = 1'b0;
    mtu_wdata_i     = '0;
    in_valid_i      = 1'b0;
    total_length_i  = '0;
    header_words_i  = '0;
    dont_fragment_i = 1'b0;
    payload_base_i  = '0;
    steady          = 1'b0;
    mtu_now         = MtuReset;
    rst_ni          = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset MTU: boundary lengths, short headers, DF and address wrap.
    send_packet(16'd1500, 4'd5, 1'b0, 32'h0000_0000);
    send_packet(16'd1501, 4'd5, 1'b1, 32'h1234_5678);
    send_packet(16'd1501, 4'd5, 1'b0, 32'hFFFF_FFF0);
    send_packet(16'd0, 4'd5, 1'b0, 32'hFFFF_FFFF);
    send_packet(16'd19, 4'd5, 1'b0, 32'h0000_0100);
    send_packet(16'd20, 4'd5, 1'b0, 32'h0000_0100);
    send_packet(16'd100, 4'd4, 1'b0, 32'h0000_0200);
    send_packet(16'd0, 4'd0, 1'b1, 32'h0000_0000);
    send_packet(16'd59, 4'd15, 1'b0, 32'h8000_0000);
    send_packet(16'd60, 4'd15, 1'b0, 32'h8000_0000);
    send_packet(16'd65535, 4'd15, 1'b0, 32'hAAAA_5555);
    send_packet(16'd65535, 4'd15, 1'b1, 32'h5555_AAAA);
    // Payload an exact multiple of the fragment size: no empty tail.
    send_packet(16'd2980, 4'd5, 1'b0, 32'hFFFF_FFFF);

    retune_mtu(65535);
    send_packet(16'd65535, 4'd5, 1'b1, 32'hFFFF_FFFF);
    send_packet(16'd65535, 4'd15, 1'b0, 32'h0F0F_0F0F);

    retune_mtu(1088);
    send_packet(16'd65535, 4'd5, 1'b0, 32'hFFFF_0000);
    send_packet(16'd1089, 4'd15, 1'b0, 32'h0000_FFFF);

    // MTU below its usual range: exactly the fragment limit, one past it.
    retune_mtu(100);
    send_packet(16'd5140, 4'd5, 1'b0, 32'hC000_0000);
    send_packet(16'd5141, 4'd5, 1'b0, 32'hC000_0000);
    send_packet(16'd65535, 4'd5, 1'b0, 32'h0000_0000);

    // MTU too small to carry a header plus one block.
    retune_mtu(24);
    send_packet(16'd25, 4'd5, 1'b0, 32'h0000_0010);
    send_packet(16'd24, 4'd5, 1'b0, 32'h0000_0010);
    send_packet(16'd61, 4'd15, 1'b0, 32'h0000_0010);
    retune_mtu(28);
    send_packet(16'd29, 4'd5, 1'b0, 32'hFFFF_FFFC);
    retune_mtu(0);
    send_packet(16'd20, 4'd5, 1'b0, 32'h0000_0000);

    // Random phases.
    retune_mtu(1088);
    random_packets(20);
    retune_mtu($urandom_range(1089, 65534));
    random_packets(20);
    steady = 1'b1;
    retune_mtu(65535);
    random_packets(15);
    steady = 1'b0;
    retune_mtu($urandom_range(1088, 4000));
    random_packets(20);
    retune_mtu(1500);
    random_packets(10);
    retune_mtu($urandom_range(20, 300));
    random_packets(10);

    drain_results();
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #40000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

### files.f
rtl/ipv4fdg_pkg.sv
rtl/ipv4fdg_ctrl.sv
rtl/ipv4fdg_dp.sv
rtl/ipv4_fragment_descriptor_gen.sv
tb/frag_checker.sv
tb/testbench.sv
